// ----- hdl/mwic_pkg.sv -----
// shared types, constants and width helpers for the window coverage block
package mwic_pkg;

    localparam int IN_W  = 32;
    localparam int CFG_W = 32;
    localparam int OUT_W = 33;
    localparam int EXT_W = 64;

    typedef logic [IN_W-1:0]  pos_in_t;
    typedef logic [CFG_W-1:0] win_len_t;
    typedef logic [OUT_W-1:0] cov_t;

    localparam cov_t     OUT_MAX       = '1;
    localparam win_len_t WIN_LEN_RESET = win_len_t'(1);

    // signed width that holds end + 1 - window_length without wrap
    function automatic int left_width(input int pos_bits);
        return ((pos_bits > CFG_W) ? pos_bits : CFG_W) + 2;
    endfunction

    // queue word: first flag, start, end, left edge
    function automatic int qword_width(input int pos_bits);
        return 1 + 2 * pos_bits + left_width(pos_bits);
    endfunction

endpackage

// ----- hdl/mwic_if.sv -----
// valid/ready channel interfaces for intervals, results and configuration

interface mwic_in_if import mwic_pkg::*; ();
    logic    valid;
    logic    ready;
    pos_in_t interval_start;
    pos_in_t interval_end;
    logic    first_of_set;

    modport source (output valid, output interval_start, output interval_end,
                    output first_of_set, input ready);
    modport sink (input valid, input interval_start, input interval_end,
                  input first_of_set, output ready);
endinterface

interface mwic_out_if import mwic_pkg::*; ();
    logic valid;
    logic ready;
    cov_t best_coverage;
    cov_t window_coverage;
    logic overflow;

    modport source (output valid, output best_coverage, output window_coverage,
                    output overflow, input ready);
    modport sink (input valid, input best_coverage, input window_coverage,
                  input overflow, output ready);
endinterface

interface mwic_cfg_if import mwic_pkg::*; ();
    logic     valid;
    logic     ready;
    win_len_t window_length;

    modport source (output valid, output window_length, input ready);
    modport sink (input valid, input window_length, output ready);
endinterface

// ----- hdl/mwic_ram.sv -----
// generic single write port ram with registered read
module mwic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- hdl/mwic_front.sv -----
// front end: takes interval words, masks positions, fixes end, forms left edge
module mwic_front import mwic_pkg::*; #(
    parameter int POS_BITS = 32,
    localparam int QW = qword_width(POS_BITS)
) (
    mwic_in_if.sink    intervals,
    input  win_len_t   window_length,
    output logic       push_valid,
    output logic [QW-1:0] push_word,
    input  logic       push_ready
);

    localparam int PW = POS_BITS;
    localparam int LW = left_width(POS_BITS);

    logic [EXT_W-1:0] start_ext;
    logic [EXT_W-1:0] end_ext;
    logic [PW-1:0]    pos_s;
    logic [PW-1:0]    pos_e;
    logic [PW-1:0]    pos_e_fix;
    logic [LW-1:0]    left_edge;

    // positions taken in their low bits
    assign start_ext = EXT_W'(intervals.interval_start);
    assign end_ext   = EXT_W'(intervals.interval_end);
    assign pos_s     = start_ext[PW-1:0];
    assign pos_e     = end_ext[PW-1:0];

    // end below start collapses to a single position
    assign pos_e_fix = (pos_e < pos_s) ? pos_s : pos_e;

    // window left edge, two's complement, may be negative
    assign left_edge = LW'(pos_e_fix) + LW'(1) - LW'(window_length);

    // hand the classified word to the queue
    assign push_word       = {intervals.first_of_set, pos_s, pos_e_fix, left_edge};
    assign push_valid      = intervals.valid;
    assign intervals.ready = push_ready;

endmodule

// ----- hdl/mwic_queue.sv -----
// two word queue between front and back
module mwic_queue #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_word,
    output logic             push_ready,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_word,
    input  logic             pop_ready
);

    localparam int QDEPTH = 2;
    localparam int QCW    = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QDEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != QCW'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- hdl/mwic_back.sv -----
// back end: interval fifo, retire loop, coverage and best tracking, result register
module mwic_back import mwic_pkg::*; #(
    parameter int FIFO_DEPTH = 64,
    parameter int POS_BITS   = 32,
    localparam int QW = qword_width(POS_BITS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  logic [QW-1:0] q_word,
    output logic          q_ready,
    mwic_out_if.source    coverage
);

    localparam int PW    = POS_BITS;
    localparam int LW    = left_width(POS_BITS);
    localparam int AW    = $clog2(FIFO_DEPTH);
    localparam int CW    = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = PW + AW + 1;
    localparam int GW    = (LW > SUM_W) ? LW : SUM_W;
    localparam int XW    = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int RW    = 2 * PW;

    localparam logic [AW-1:0] LAST_SLOT  = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // control state
    logic             state_reg,   state_next;
    logic [AW-1:0]    head_reg,    head_next;
    logic [AW-1:0]    tail_reg,    tail_next;
    logic [CW-1:0]    count_reg,   count_next;
    logic [SUM_W-1:0] sum_reg,     sum_next;
    cov_t             best_reg,    best_next;
    logic             ovf_reg,     ovf_next;
    logic             hsel_reg,    hsel_next;
    logic             out_valid_reg, out_valid_next;

    // payload state
    logic [LW-1:0]    left_reg,    left_next;
    logic [PW-1:0]    cache_lo_reg, cache_lo_next;
    logic [PW-1:0]    cache_hi_reg, cache_hi_next;
    cov_t             out_best_reg, out_best_next;
    cov_t             out_cov_reg,  out_cov_next;
    logic             out_ovf_reg,  out_ovf_next;

    // queue word fields
    logic             q_first;
    logic [PW-1:0]    q_s;
    logic [PW-1:0]    q_e;
    logic [LW-1:0]    q_left;

    // ram port signals
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [RW-1:0]    rd_data;

    // set-clear view of the state
    logic [AW-1:0]    eff_head;
    logic [AW-1:0]    eff_tail;
    logic [CW-1:0]    eff_count;
    logic [SUM_W-1:0] eff_sum;
    cov_t             eff_best;
    logic             eff_ovf;

    // head entry and coverage path
    logic [PW-1:0]    head_lo;
    logic [PW-1:0]    head_hi;
    logic [SUM_W-1:0] head_len;
    logic [SUM_W-1:0] new_len;
    logic             pop_now;
    logic [LW-1:0]    gap;
    logic             gap_pos;
    logic [GW-1:0]    gap_x;
    logic [GW-1:0]    sum_x;
    logic [GW-1:0]    cov_g;
    logic [XW-1:0]    cov_x;
    cov_t             cov_sat;
    cov_t             best_upd;
    logic             slot_free;

    assign q_first = q_word[QW-1];
    assign q_s     = q_word[QW-2 -: PW];
    assign q_e     = q_word[QW-2-PW -: PW];
    assign q_left  = q_word[LW-1:0];

    // a first word starts from an empty set
    assign eff_head  = q_first ? '0 : head_reg;
    assign eff_tail  = q_first ? '0 : tail_reg;
    assign eff_count = q_first ? '0 : count_reg;
    assign eff_sum   = q_first ? '0 : sum_reg;
    assign eff_best  = q_first ? '0 : best_reg;
    assign eff_ovf   = q_first ? 1'b0 : ovf_reg;

    assign new_len = SUM_W'(q_e) - SUM_W'(q_s) + SUM_W'(1);

    // head entry comes from the cache or from the last ram read
    assign head_lo  = hsel_reg ? rd_data[RW-1:PW] : cache_lo_reg;
    assign head_hi  = hsel_reg ? rd_data[PW-1:0]  : cache_hi_reg;
    assign head_len = SUM_W'(head_hi) - SUM_W'(head_lo) + SUM_W'(1);

    // retire the head when it ends left of the window
    assign pop_now = (count_reg != '0) && ($signed(LW'(head_hi)) < $signed(left_reg));

    // uncovered part of the oldest interval
    assign gap     = left_reg - LW'(head_lo);
    assign gap_pos = (count_reg != '0) && !gap[LW-1] && (gap != '0);
    assign gap_x   = GW'(gap);
    assign sum_x   = GW'(sum_reg);
    assign cov_g   = !gap_pos ? sum_x : ((gap_x >= sum_x) ? '0 : sum_x - gap_x);
    assign cov_x   = XW'(cov_g[SUM_W-1:0]);
    assign cov_sat = (cov_x > XW'(OUT_MAX)) ? OUT_MAX : cov_x[OUT_W-1:0];
    assign best_upd = (cov_sat > best_reg) ? cov_sat : best_reg;

    assign slot_free = !out_valid_reg || coverage.ready;
    assign q_ready   = (state_reg == S_IDLE);

    // push and retire sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        hsel_next      = hsel_reg;
        left_next      = left_reg;
        cache_lo_next  = cache_lo_reg;
        cache_hi_next  = cache_hi_reg;
        out_valid_next = out_valid_reg;
        out_best_next  = out_best_reg;
        out_cov_next   = out_cov_reg;
        out_ovf_next   = out_ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = eff_tail;
        rd_en          = 1'b0;
        rd_addr        = next_slot(head_reg);

        if (coverage.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    head_next  = eff_head;
                    tail_next  = eff_tail;
                    count_next = eff_count;
                    sum_next   = eff_sum;
                    best_next  = eff_best;
                    ovf_next   = eff_ovf;
                    left_next  = q_left;
                    if (eff_count == FULL_COUNT)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        tail_next  = next_slot(eff_tail);
                        count_next = eff_count + CW'(1);
                        sum_next   = eff_sum + new_len;
                        if (eff_count == '0)
                        begin
                            cache_lo_next = q_s;
                            cache_hi_next = q_e;
                            hsel_next     = 1'b0;
                        end
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (pop_now)
                begin
                    sum_next   = sum_reg - head_len;
                    head_next  = next_slot(head_reg);
                    count_next = count_reg - CW'(1);
                    rd_en      = 1'b1;
                    hsel_next  = 1'b1;
                end
                else if (slot_free)
                begin
                    best_next      = best_upd;
                    out_valid_next = 1'b1;
                    out_best_next  = best_upd;
                    out_cov_next   = cov_sat;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            hsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            hsel_reg      <= hsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        cache_lo_reg <= cache_lo_next;
        cache_hi_reg <= cache_hi_next;
        out_best_reg <= out_best_next;
        out_cov_reg  <= out_cov_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // interval storage
    mwic_ram #(
        .WIDTH (RW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({q_s, q_e}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result word
    assign coverage.valid           = out_valid_reg;
    assign coverage.best_coverage   = out_best_reg;
    assign coverage.window_coverage = out_cov_reg;
    assign coverage.overflow        = out_ovf_reg;

endmodule

// ----- hdl/max_window_interval_coverage.sv -----
// Sliding-window interval coverage. Each accepted interval word is pushed into an
// on-chip interval fifo (FIFO_DEPTH entries) unless the fifo is full, which sets
// overflow instead; intervals that end left of the window are retired one per
// cycle, and one result word is produced per interval. The back-end sequencer
// pushes an interval, retires intervals, then forms the result once the result
// register is free, and takes a new interval only after that; every interval is
// retired at most once. A two-word queue lets the front accept intervals while
// the back end is busy, and the result register lets the back end start the next
// interval while a result waits. No clearing pass is needed after reset.
// window_length resets to 1; the user must write it only while idle, as the
// block itself does not enforce this.
module max_window_interval_coverage import mwic_pkg::*; #(
    parameter int FIFO_DEPTH = 64,
    parameter int POS_BITS   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    mwic_cfg_if.sink   cfg,
    mwic_in_if.sink    intervals,
    mwic_out_if.source coverage
);

    localparam int QW = qword_width(POS_BITS);

    win_len_t      window_length_reg;
    logic          push_valid;
    logic [QW-1:0] push_word;
    logic          push_ready;
    logic          pop_valid;
    logic [QW-1:0] pop_word;
    logic          pop_ready;

    // window length register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WIN_LEN_RESET;
        end
        else if (cfg.valid)
        begin
            window_length_reg <= cfg.window_length;
        end
    end

    // front end
    mwic_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .intervals     (intervals),
        .window_length (window_length_reg),
        .push_valid    (push_valid),
        .push_word     (push_word),
        .push_ready    (push_ready)
    );

    // decoupling queue
    mwic_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_word   (pop_word),
        .pop_ready  (pop_ready)
    );

    // back end
    mwic_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .POS_BITS   (POS_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_word   (pop_word),
        .q_ready  (pop_ready),
        .coverage (coverage)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the sliding-window interval coverage block
module testbench;
    import mwic_pkg::*;

    localparam int DEPTH = 64;
    localparam longint COV_CAP = (longint'(1) << 33) - 1;
    localparam win_len_t WIN_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        pos_in_t interval_start;
        pos_in_t interval_end;
        logic    first_of_set;
    } interval_t;

    typedef struct packed {
        cov_t best_coverage;
        cov_t window_coverage;
        logic overflow;
    } coverage_t;

    logic clk;
    logic rst_n;

    mwic_cfg_if cfg_ch ();
    mwic_in_if  in_ch ();
    mwic_out_if out_ch ();

    max_window_interval_coverage #(
        .FIFO_DEPTH(DEPTH),
        .POS_BITS  (32)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .intervals(in_ch),
        .coverage (out_ch)
    );

    // intervals waiting to be sent, coverage words waiting to arrive
    interval_t interval_q[$];
    coverage_t coverage_q[$];
    interval_t drive_item;

    // shadow of the block's state
    win_len_t win_len;
    longint   span_lo[DEPTH];
    longint   span_hi[DEPTH];
    int       span_head;
    int       span_tail;
    int       span_count;
    longint   span_sum;
    longint   top_cov;
    logic     full_seen;

    int errors;
    int n_queued;
    int n_items;
    int n_words;
    int n_sets;
    int n_overflow;
    int n_saturated;
    int n_windows;

    // burst odds: 0 means no idling, else one burst start in that many cycles
    int send_odds;
    int stall_odds;
    int send_gap;
    int stall_left;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // coverage of the window ending on this interval, updates the shadow state
    function automatic coverage_t cover_step(input interval_t it);
        longint s;
        longint e;
        longint lft;
        longint gap;
        longint c;
        coverage_t r;
        s = longint'({32'd0, it.interval_start});
        e = longint'({32'd0, it.interval_end});
        if (it.first_of_set)
        begin
            span_head  = 0;
            span_tail  = 0;
            span_count = 0;
            span_sum   = 0;
            top_cov    = 0;
            full_seen  = 1'b0;
        end
        // end below start collapses to one position
        if (e < s)
            e = s;
        if (span_count >= DEPTH)
            full_seen = 1'b1;
        else
        begin
            span_lo[span_tail] = s;
            span_hi[span_tail] = e;
            span_tail = (span_tail + 1) % DEPTH;
            span_count++;
            span_sum += e - s + 1;
        end
        lft = e + 1 - longint'({32'd0, win_len});
        // retire intervals ending left of the window
        while (span_count > 0 && span_hi[span_head] < lft)
        begin
            span_sum -= span_hi[span_head] - span_lo[span_head] + 1;
            span_head = (span_head + 1) % DEPTH;
            span_count--;
        end
        c = span_sum;
        // drop the part of the oldest interval left of the window
        if (span_count > 0)
        begin
            gap = lft - span_lo[span_head];
            if (gap > 0)
                c = (gap >= c) ? 0 : c - gap;
        end
        if (c > COV_CAP)
            c = COV_CAP;
        if (c > top_cov)
            top_cov = c;
        r.best_coverage   = top_cov[32:0];
        r.window_coverage = c[32:0];
        r.overflow        = full_seen;
        return r;
    endfunction

    // interval sender
    always @(posedge clk)
    begin : sender
        logic took;
        took = in_ch.valid && in_ch.ready;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (took)
            begin
                coverage_q.push_back(cover_step(drive_item));
                n_items++;
                if (drive_item.first_of_set)
                    n_sets++;
            end
            if (!in_ch.valid || took)
            begin
                if (interval_q.size() == 0)
                    in_ch.valid <= 1'b0;
                else if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (send_odds != 0 && $urandom_range(0, send_odds - 1) == 0)
                begin
                    send_gap = $urandom_range(0, 10);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    drive_item = interval_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.interval_start <= drive_item.interval_start;
                    in_ch.interval_end   <= drive_item.interval_end;
                    in_ch.first_of_set   <= drive_item.first_of_set;
                end
            end
        end
    end

    // coverage word receiver and checker
    always @(posedge clk)
    begin : receiver
        coverage_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_words++;
                if (out_ch.overflow)
                    n_overflow++;
                if (out_ch.window_coverage == OUT_MAX)
                    n_saturated++;
                if (coverage_q.size() == 0)
                begin
                    errors++;
                    $error("coverage word with nothing expected: best %0d window %0d",
                           out_ch.best_coverage, out_ch.window_coverage);
                end
                else
                begin
                    want = coverage_q.pop_front();
                    if (out_ch.best_coverage !== want.best_coverage)
                    begin
                        errors++;
                        $error("best_coverage: expected %0d, got %0d",
                               want.best_coverage, out_ch.best_coverage);
                    end
                    if (out_ch.window_coverage !== want.window_coverage)
                    begin
                        errors++;
                        $error("window_coverage: expected %0d, got %0d",
                               want.window_coverage, out_ch.window_coverage);
                    end
                    if (out_ch.overflow !== want.overflow)
                    begin
                        errors++;
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, out_ch.overflow);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic queue_interval(input pos_in_t s, input pos_in_t e, input logic f);
        interval_t it;
        it.interval_start = s;
        it.interval_end   = e;
        it.first_of_set   = f;
        interval_q.push_back(it);
        n_queued++;
    endtask

    // wait until every queued interval has been answered
    task automatic drain();
        do
            @(posedge clk);
        while (n_items != n_queued || coverage_q.size() != 0);
        // let the block sit idle a while before the next phase
        repeat (80) @(posedge clk);
    endtask

    task automatic write_window(input win_len_t v);
        cfg_ch.window_length <= v;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        win_len = v;
        n_windows++;
    endtask

    // mostly ascending disjoint sets scaled to the window, plus some noise
    task automatic plan_phase(input int n);
        int remaining;
        int cnt;
        int k;
        longint unit;
        longint p;
        longint ln;
        remaining = n;
        while (remaining > 0)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                queue_interval($urandom, $urandom, 1'($urandom_range(0, 1)));
                remaining--;
            end
            else
            begin
                unit = longint'({32'd0, win_len}) / $urandom_range(1, 200);
                if (unit < 1)
                    unit = 1;
                p = ($urandom_range(0, 3) == 0) ? longint'({32'd0, $urandom})
                                                : longint'($urandom_range(0, 255));
                cnt = $urandom_range(1, 90);
                for (k = 0; k < cnt && remaining > 0; k++)
                begin
                    ln = $urandom_range(0, 32'(unit));
                    if (p + ln > 64'hFFFF_FFFF)
                        break;
                    queue_interval(32'(p), 32'(p + ln), k == 0);
                    remaining--;
                    p = p + ln + 1 + $urandom_range(0, 32'(unit));
                end
            end
        end
    endtask

    initial
    begin : run
        int ph;
        win_len_t w;
        errors = 0;
        n_queued = 0;
        n_items = 0;
        n_words = 0;
        n_sets = 0;
        n_overflow = 0;
        n_saturated = 0;
        n_windows = 0;
        send_odds = 0;
        stall_odds = 0;
        win_len = WIN_LEN_RESET;
        span_head = 0;
        span_tail = 0;
        span_count = 0;
        span_sum = 0;
        top_cov = 0;
        full_seen = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.window_length = '0;
        in_ch.valid = 1'b0;
        in_ch.interval_start = '0;
        in_ch.interval_end = '0;
        in_ch.first_of_set = 1'b0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // window at its reset length, extremes and end below start
        send_odds = 4;
        stall_odds = 4;
        queue_interval(32'd0, 32'd0, 1'b1);
        queue_interval(32'd5, 32'd9, 1'b0);
        queue_interval(32'd20, 32'd15, 1'b0);
        queue_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_interval(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        queue_interval(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        drain();

        // zero length window retires everything
        write_window('0);
        queue_interval(32'd10, 32'd20, 1'b1);
        queue_interval(32'd30, 32'd30, 1'b0);
        queue_interval(32'd40, 32'd90, 1'b0);
        drain();

        // widest window: overlapping full-range intervals saturate
        write_window(WIN_MAX);
        queue_interval(32'd0, 32'hFFFF_FFFF, 1'b1);
        queue_interval(32'd0, 32'hFFFF_FFFF, 1'b0);
        queue_interval(32'd0, 32'hFFFF_FFFF, 1'b0);
        queue_interval(32'd100, 32'd200, 1'b1);
        queue_interval(32'd50, 32'd60, 1'b0);
        drain();

        // short window with a partly covered oldest interval
        write_window(32'd3);
        queue_interval(32'd0, 32'd9, 1'b1);
        queue_interval(32'd12, 32'd15, 1'b0);
        queue_interval(32'd17, 32'd17, 1'b0);
        queue_interval(32'd18, 32'd30, 1'b0);
        drain();

        // fill the interval fifo past its depth in one set
        write_window(32'd1000);
        send_odds = 0;
        stall_odds = 6;
        for (int i = 0; i < DEPTH + 4; i++)
            queue_interval(32'(2 * i), 32'(2 * i), i == 0);
        drain();

        // random phases over a spread of window lengths
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: w = 32'd1;
                1: w = 32'd2;
                2: w = $urandom_range(3, 40);
                3: w = $urandom_range(41, 5000);
                4: w = $urandom_range(5001, 32'hF_FFFF);
                5: w = $urandom;
                6: w = WIN_MAX;
                default: w = 32'h8000_0000;
            endcase
            write_window(w);
            send_odds  = (ph % 3 == 0) ? 3 : (ph % 3 == 1) ? 9 : 40;
            stall_odds = (ph % 2 == 0) ? 5 : 30;
            plan_phase(225);
            drain();
        end

        // closing stretch at full rate
        write_window($urandom_range(1, 300));
        send_odds = 0;
        stall_odds = 0;
        plan_phase(100);
        drain();

        $display("%0d intervals in %0d sets over %0d window lengths, %0d words checked",
                 n_items, n_sets, n_windows, n_words);
        $display("%0d words flagged overflow, %0d saturated coverage values",
                 n_overflow, n_saturated);
        if (errors == 0)
            $display("max_window_interval_coverage: match");
        else
            $display("max_window_interval_coverage: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("max_window_interval_coverage: mismatch");
        $finish;
    end

endmodule
